>>> rtl/fifs_pkg.sv
// Shared types and constants for the frame index floor search block.
package fifs_pkg;

   // Word field widths
   localparam int OP_W     = 2;
   localparam int FRAME_W  = 24;
   localparam int ADDR_W   = 32;
   localparam int STATUS_W = 2;

   // Operation codes
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_RISING = 2'd3;

   // Sequencer states, one-hot
   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_WAIT   = 4'b0100,
      S_FETCH  = 4'b1000
   } state_type;

endpackage

>>> rtl/fifs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fifs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/frame_index_floor_search.sv
// Frame index table: clear, append and floor lookup by binary search.
//
// Usage: drive req_op, req_frame_number and req_block_address with start high;
// the word is taken at the clock edge where start is high and busy is low.
// Each word produces exactly one result word, shown for one cycle with
// rsp_valid high; the receiver cannot stall it and must take it then.
// Clear, append, an unused op and a query that falls outside the stored span
// answer in the cycle after acceptance and keep busy low, so words may
// follow back to back. A query that hits runs a binary search over the frame
// RAM, each probe issuing a RAM read in S_SEARCH and comparing in S_WAIT,
// then reads both RAMs at the found entry and registers the result in S_FETCH;
// the search takes at most ceil(log2(entry count)) probes, with busy high
// until the result is shown.
// First and last stored frames sit in registers so appends and range checks
// need no RAM read. Reset empties the table at once; RAM contents are not
// cleared and entries beyond the count are never read.
module frame_index_floor_search #(
   parameter int MAX_ENTRIES = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [fifs_pkg::OP_W-1:0]         req_op,
   input  logic [fifs_pkg::FRAME_W-1:0]      req_frame_number,
   input  logic [fifs_pkg::ADDR_W-1:0]       req_block_address,
   output logic                              rsp_valid,
   output logic [fifs_pkg::STATUS_W-1:0]     rsp_status,
   output logic [fifs_pkg::ADDR_W-1:0]       rsp_found_address,
   output logic [fifs_pkg::FRAME_W-1:0]      rsp_found_frame
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

   fifs_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    lo_ff, lo_in;
   logic [IDX_W-1:0]    hi_ff, hi_in;
   logic [IDX_W-1:0]    mid_ff, mid_in;
   logic [fifs_pkg::FRAME_W-1:0] key_ff, key_in;
   logic [fifs_pkg::FRAME_W-1:0] first_ff, first_in;
   logic [fifs_pkg::FRAME_W-1:0] last_ff, last_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [fifs_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [fifs_pkg::ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic [fifs_pkg::FRAME_W-1:0]    rsp_frame_ff, rsp_frame_in;

   logic                            accept;
   logic [CNT_W-1:0]                span;
   logic [IDX_W-1:0]                mid;
   logic                            wr_en;
   logic                            rd_en;
   logic [IDX_W-1:0]                rd_addr;
   logic [fifs_pkg::FRAME_W-1:0]    frame_rd;
   logic [fifs_pkg::ADDR_W-1:0]     addr_rd;

   assign busy   = (state_ff != fifs_pkg::S_IDLE);
   assign accept = start && !busy;

   // upper midpoint of the live interval
   assign span = CNT_W'(hi_ff) - CNT_W'(lo_ff) + CNT_W'(1);
   assign mid  = lo_ff + IDX_W'(span >> 1);

   // frame and address storage
   fifs_ram #(.WIDTH(fifs_pkg::FRAME_W), .DEPTH(MAX_ENTRIES)) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_frame_number),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (frame_rd)
   );

   fifs_ram #(.WIDTH(fifs_pkg::ADDR_W), .DEPTH(MAX_ENTRIES)) u_addr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_block_address),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (addr_rd)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      key_in        = key_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = fifs_pkg::ST_OK;
      rsp_addr_in   = '0;
      rsp_frame_in  = '0;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = lo_ff;

      unique case (state_ff)
         fifs_pkg::S_IDLE: begin
            if (accept) begin
               key_in = req_frame_number;
               case (req_op)
                  fifs_pkg::OP_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  fifs_pkg::OP_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == MAX_CNT) begin
                        rsp_status_in = fifs_pkg::ST_FULL;
                     end else if (count_ff != '0 && req_frame_number <= last_ff) begin
                        rsp_status_in = fifs_pkg::ST_NOT_RISING;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        last_in  = req_frame_number;
                        if (count_ff == '0) begin
                           first_in = req_frame_number;
                        end
                     end
                  end
                  fifs_pkg::OP_QUERY: begin
                     if (count_ff == '0 || req_frame_number < first_ff ||
                         req_frame_number > last_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = fifs_pkg::ST_RANGE;
                     end else begin
                        lo_in    = '0;
                        hi_in    = IDX_W'(count_ff - CNT_W'(1));
                        state_in = fifs_pkg::S_SEARCH;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = fifs_pkg::ST_RANGE;
                  end
               endcase
            end
         end
         fifs_pkg::S_SEARCH: begin
            rd_en = 1'b1;
            if (lo_ff < hi_ff) begin
               // probe the midpoint
               rd_addr  = mid;
               mid_in   = mid;
               state_in = fifs_pkg::S_WAIT;
            end else begin
               // interval closed: fetch the found entry
               rd_addr  = lo_ff;
               state_in = fifs_pkg::S_FETCH;
            end
         end
         fifs_pkg::S_WAIT: begin
            if (frame_rd <= key_ff) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff - IDX_W'(1);
            end
            state_in = fifs_pkg::S_SEARCH;
         end
         fifs_pkg::S_FETCH: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = fifs_pkg::ST_OK;
            rsp_addr_in   = addr_rd;
            rsp_frame_in  = frame_rd;
            state_in      = fifs_pkg::S_IDLE;
         end
         default: begin
            state_in = fifs_pkg::S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fifs_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      key_ff        <= key_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_frame_ff  <= rsp_frame_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_address = rsp_addr_ff;
   assign rsp_found_frame   = rsp_frame_ff;

`ifndef NO_ASSERTIONS
   // a non-query word always answers in the next cycle
   a_quick_answer: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op != fifs_pkg::OP_QUERY) |=> rsp_valid)
      else $error("non-query word gave no result in the next cycle");

   // entry count never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("entry count exceeds capacity");

   // search interval stays ordered and inside the table
   a_interval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fifs_pkg::S_SEARCH) |->
         (lo_ff <= hi_ff && CNT_W'(hi_ff) < count_ff))
      else $error("search interval out of order");

   // failed words carry zero payload
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != fifs_pkg::ST_OK) |->
         (rsp_found_address == '0 && rsp_found_frame == '0))
      else $error("non-ok result with nonzero payload");
`endif

endmodule
